// ----- rtl/rnp_pkg.sv -----
// Shared types, codes and character helpers for the radix number parser.
`timescale 1ns / 1ps

package rnp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int RADIX_W         = 6;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] NO_WEIGHT   = 6'd36;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_B_UP  = 8'h42;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [RADIX_W-1:0] radix;
        logic               minus;
        logic               any;
    } ctrl_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
    endfunction

    // digit weight, NO_WEIGHT for non-alphanumeric bytes
    function automatic logic [RADIX_W-1:0] weight_of(input logic [7:0] c);
        logic [7:0] w;
        w = 8'd36;
        if (c inside {[8'h30:8'h39]}) begin
            w = c - 8'h30;
        end else if (c inside {[8'h61:8'h7A]}) begin
            w = c - 8'h61 + 8'd10;
        end else if (c inside {[8'h41:8'h5A]}) begin
            w = c - 8'h41 + 8'd10;
        end
        return w[RADIX_W-1:0];
    endfunction

endpackage

// ----- rtl/radix_number_parser.sv -----
// Top level of the streaming string-to-unsigned-integer parser.
//
//  channel   dir  handshake                   contents
//  s_axis    in   s_axis_tvalid/tready        tdata: char_in; tuser: start_flag
//  m_axis    out  m_axis_tvalid/tready        tdata: parsed_value, bytes_consumed
//                                             tuser: digits_found
//  cfg       in   cfg_wr_en                   cfg_wr_data: radix_setting
//
// One item per cycle while s_axis_tready is high; parse state updates in the accepting cycle
// through one 64x6 multiply-add, and each result is registered into the result register or the skid.
// A two-entry output buffer (result register plus skid) keeps s_axis_tready
// high while one result waits; it drops only when both entries are full.
// aresetn is synchronous, active low; radix_setting resets to 10.
`timescale 1ns / 1ps

module radix_number_parser #(
    parameter int VALUE_WIDTH = rnp_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = rnp_pkg::COUNT_WIDTH_DEF,
    localparam int TDATA_W    = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] char_in
    input  logic                        s_axis_tuser,   // [0] start_flag
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [TDATA_W-1:0]          m_axis_tdata,   // parsed_value, bytes_consumed, zero pad
    output logic                        m_axis_tuser,   // [0] digits_found
    input  logic                        cfg_wr_en,
    input  logic [rnp_pkg::RADIX_W-1:0] cfg_wr_data     // radix_setting
);

    localparam int RES_W = VALUE_WIDTH + COUNT_WIDTH + 1;

    logic [rnp_pkg::RADIX_W-1:0] radix_cfg_reg;
    rnp_pkg::ctrl_t              ctrl_reg;
    rnp_pkg::ctrl_t              ctrl_next;
    logic [VALUE_WIDTH-1:0]      acc_reg;
    logic [VALUE_WIDTH-1:0]      acc_next;
    logic [COUNT_WIDTH-1:0]      pos_reg;
    logic [COUNT_WIDTH-1:0]      pos_next;
    logic                        emit;
    logic [VALUE_WIDTH-1:0]      res_value;
    logic [COUNT_WIDTH-1:0]      res_count;
    logic                        res_digits;
    logic [RES_W-1:0]            res_word;
    logic [RES_W-1:0]            out_reg;
    logic [RES_W-1:0]            skid_reg;
    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    logic                        in_fire;
    logic                        out_fire;

    rnp_step #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .char_in    (s_axis_tdata),
        .start_flag (s_axis_tuser),
        .cfg_radix  (radix_cfg_reg),
        .ctrl_cur   (ctrl_reg),
        .acc_cur    (acc_reg),
        .pos_cur    (pos_reg),
        .ctrl_next  (ctrl_next),
        .acc_next   (acc_next),
        .pos_next   (pos_next),
        .emit       (emit),
        .res_value  (res_value),
        .res_count  (res_count),
        .res_digits (res_digits)
    );

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign res_word      = {res_digits, res_count, res_value};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_reg[VALUE_WIDTH+COUNT_WIDTH-1:0]);
    assign m_axis_tuser  = out_reg[RES_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_cfg_reg  <= rnp_pkg::RADIX_RESET;
            ctrl_reg       <= '{phase: rnp_pkg::PH_IDLE, radix: '0, minus: 1'b0, any: 1'b0};
            acc_reg        <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radix_cfg_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                ctrl_reg <= ctrl_next;
                acc_reg  <= acc_next;
                pos_reg  <= pos_next;
            end
            if (in_fire && emit) begin
                if (!out_valid_reg || out_fire) begin
                    out_reg       <= res_word;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res_word;
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_fire) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/rnp_step.sv -----
// Next-state and result logic for one item of the parser.
`timescale 1ns / 1ps

module rnp_step #(
    parameter int VALUE_WIDTH = rnp_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = rnp_pkg::COUNT_WIDTH_DEF
) (
    input  logic [7:0]                   char_in,
    input  logic                         start_flag,
    input  logic [rnp_pkg::RADIX_W-1:0]  cfg_radix,
    input  rnp_pkg::ctrl_t               ctrl_cur,
    input  logic [VALUE_WIDTH-1:0]       acc_cur,
    input  logic [COUNT_WIDTH-1:0]       pos_cur,
    output rnp_pkg::ctrl_t               ctrl_next,
    output logic [VALUE_WIDTH-1:0]       acc_next,
    output logic [COUNT_WIDTH-1:0]       pos_next,
    output logic                         emit,
    output logic [VALUE_WIDTH-1:0]       res_value,
    output logic [COUNT_WIDTH-1:0]       res_count,
    output logic                         res_digits
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    rnp_pkg::ctrl_t                  base;
    logic [VALUE_WIDTH-1:0]          acc_b;
    logic [COUNT_WIDTH-1:0]          pos_b;
    logic                            active;
    logic                            do_digit;
    logic                            zero_pref;
    logic                            digit_ok;
    logic                            first_auto;
    logic                            zero_auto;
    logic [rnp_pkg::RADIX_W-1:0]     dr;
    logic [rnp_pkg::RADIX_W-1:0]     w;
    logic [COUNT_WIDTH-1:0]          end_pos;
    logic [VALUE_WIDTH+5:0]          prod;
    logic [VALUE_WIDTH-1:0]          mac;
    logic [VALUE_WIDTH-1:0]          signed_val;

    always_comb begin
        if (start_flag) begin
            base.phase = rnp_pkg::PH_LEAD;
            base.radix = cfg_radix;
            base.minus = 1'b0;
            base.any   = 1'b0;
            acc_b      = '0;
            pos_b      = '0;
            active     = 1'b1;
        end else begin
            base   = ctrl_cur;
            acc_b  = acc_cur;
            pos_b  = (pos_cur == COUNT_MAX) ? pos_cur : pos_cur + 1'b1;
            active = (ctrl_cur.phase != rnp_pkg::PH_IDLE);
        end
    end

    // auto radix resolves to decimal on a first digit, octal after a leading zero
    assign first_auto = (base.phase == rnp_pkg::PH_LEAD || base.phase == rnp_pkg::PH_SIGNED) &&
                        (base.radix == rnp_pkg::RADIX_AUTO);
    assign zero_auto  = (base.phase == rnp_pkg::PH_ZERO) && (base.radix == rnp_pkg::RADIX_AUTO);
    assign dr         = first_auto ? rnp_pkg::RADIX_DEC :
                        zero_auto  ? rnp_pkg::RADIX_OCT : base.radix;

    assign w         = rnp_pkg::weight_of(char_in);
    assign zero_pref = (char_in == rnp_pkg::CH_ZERO) &&
                       (base.radix == rnp_pkg::RADIX_AUTO || base.radix == rnp_pkg::RADIX_BIN ||
                        base.radix == rnp_pkg::RADIX_HEX);
    assign prod      = acc_b * dr;
    assign mac       = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(w);
    assign digit_ok  = (dr >= rnp_pkg::RADIX_BIN) && (dr <= rnp_pkg::RADIX_MAX) && (w < dr);
    assign signed_val = base.minus ? ('0 - acc_b) : acc_b;

    always_comb begin
        ctrl_next  = ctrl_cur;
        acc_next   = acc_cur;
        pos_next   = pos_cur;
        emit       = 1'b0;
        do_digit   = 1'b0;
        end_pos    = pos_b;
        res_value  = base.any ? signed_val : '0;
        res_digits = base.any;

        if (active) begin
            ctrl_next = base;
            acc_next  = acc_b;
            pos_next  = pos_b;
            case (base.phase)
                rnp_pkg::PH_LEAD, rnp_pkg::PH_SIGNED: begin
                    if (base.phase == rnp_pkg::PH_LEAD && rnp_pkg::is_blank(char_in)) begin
                        ctrl_next = base;
                    end else if (base.phase == rnp_pkg::PH_LEAD &&
                                 (char_in == rnp_pkg::CH_PLUS ||
                                  char_in == rnp_pkg::CH_MINUS)) begin
                        ctrl_next.minus = (char_in == rnp_pkg::CH_MINUS);
                        ctrl_next.phase = rnp_pkg::PH_SIGNED;
                    end else if (zero_pref) begin
                        acc_next        = '0;
                        ctrl_next.any   = 1'b1;
                        ctrl_next.phase = rnp_pkg::PH_ZERO;
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                rnp_pkg::PH_ZERO: begin
                    if ((char_in == rnp_pkg::CH_X_LO || char_in == rnp_pkg::CH_X_UP) &&
                        (base.radix == rnp_pkg::RADIX_AUTO ||
                         base.radix == rnp_pkg::RADIX_HEX)) begin
                        ctrl_next.radix = rnp_pkg::RADIX_HEX;
                        ctrl_next.phase = rnp_pkg::PH_PREFIX;
                    end else if ((char_in == rnp_pkg::CH_B_LO || char_in == rnp_pkg::CH_B_UP) &&
                        (base.radix == rnp_pkg::RADIX_AUTO ||
                         base.radix == rnp_pkg::RADIX_BIN)) begin
                        ctrl_next.radix = rnp_pkg::RADIX_BIN;
                        ctrl_next.phase = rnp_pkg::PH_PREFIX;
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                rnp_pkg::PH_PREFIX: begin
                    // a bare prefix ends the number right after the leading zero
                    do_digit = 1'b1;
                    end_pos  = (pos_b == COUNT_MAX) ? COUNT_MAX : pos_b - 1'b1;
                end
                rnp_pkg::PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                default: begin
                    ctrl_next.phase = rnp_pkg::PH_IDLE;
                end
            endcase

            if (do_digit) begin
                ctrl_next.radix = dr;
                if (digit_ok) begin
                    acc_next        = mac;
                    ctrl_next.any   = 1'b1;
                    ctrl_next.phase = rnp_pkg::PH_DIGITS;
                end else begin
                    emit            = 1'b1;
                    ctrl_next.phase = rnp_pkg::PH_IDLE;
                end
            end
        end
        res_count = base.any ? end_pos : '0;
    end

endmodule

// ----- rtl/rnp_checker.sv -----
// Port-level assertions for the parser, bound to the top level.
`timescale 1ns / 1ps

module rnp_checker #(
    parameter int VALUE_WIDTH = rnp_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = rnp_pkg::COUNT_WIDTH_DEF,
    localparam int TDATA_W    = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    logic [COUNT_WIDTH-1:0] count_seen;
    assign count_seen = m_axis_tdata[VALUE_WIDTH+COUNT_WIDTH-1:VALUE_WIDTH];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_no_digit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("result without digits carries nonzero data");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> count_seen != '0)
        else $error("result with digits reports zero bytes consumed");

    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind radix_number_parser rnp_checker #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
) u_rnp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
